@@ rtl/esdc_pkg.sv @@
// ----------------------------------------------------------------------------
// esdc_pkg
// Shared types, constants and the month table for the epoch seconds / date
// converter.
// ----------------------------------------------------------------------------
`default_nettype none

package esdc_pkg;

  typedef struct packed {
    logic        func;
    logic [6:0]  in_year;
    logic [3:0]  in_month;
    logic [4:0]  in_day;
    logic [4:0]  in_hour;
    logic [5:0]  in_minute;
    logic [5:0]  in_second;
    logic [31:0] in_epoch_seconds;
  } req_t;

  typedef struct packed {
    logic [31:0] out_epoch_seconds;
    logic [6:0]  out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [5:0]  out_second;
    logic        range_error;
  } res_t;

  localparam logic FUNC_DATE_TO_SECS = 1'b0;
  localparam logic FUNC_SECS_TO_DATE = 1'b1;

  // pipeline depths (registered stages inside each unit)
  localparam int S2D_DEPTH = 7;
  localparam int D2S_DEPTH = 3;
  localparam int D2S_PAD   = S2D_DEPTH - D2S_DEPTH;
  localparam int TOP_LATENCY = S2D_DEPTH + 1;

  localparam logic [31:0] SECS_PER_DAY    = 32'd86400;
  localparam logic [16:0] SECS_PER_HOUR   = 17'd3600;
  localparam logic [11:0] SECS_PER_MIN    = 12'd60;
  localparam logic [15:0] DAYS_PER_QUAD   = 16'd1461;
  localparam logic [15:0] DAYS_UNTIL_2100 = 16'd36525;
  localparam logic [15:0] DAYS_PER_YEAR   = 16'd365;
  localparam logic [10:0] QUAD_Y1         = 11'd366;
  localparam logic [10:0] QUAD_Y2         = 11'd731;
  localparam logic [10:0] QUAD_Y3         = 11'd1096;

  // reciprocal multipliers: estimate is exact or one low
  localparam logic [25:0] DIV675_MUL   = 26'd50903316; // 2^35 / 675
  localparam int          DIV675_SHIFT = 35;
  localparam logic [10:0] HOUR_MUL     = 11'd1165;     // 2^22 / 3600
  localparam logic [15:0] QUAD_MUL     = 16'd45933;    // 2^26 / 1461
  localparam logic [10:0] MIN_MUL      = 11'd1092;     // 2^16 / 60

  // days in the year before the first of month mo (1..12)
  function automatic logic [8:0] cum_days(input logic [3:0] mo, input logic leap);
    logic [8:0] base;
    case (mo)
      4'd1:    base = 9'd0;
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && (mo > 4'd2)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

`default_nettype wire

@@ rtl/esdc_d2s.sv @@
// ----------------------------------------------------------------------------
// esdc_d2s
// Date-time to seconds: day count, scale by seconds per day, add time of
// day, then a delay line to line up with the seconds-to-date unit.
// ----------------------------------------------------------------------------
`default_nettype none

module esdc_d2s import esdc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        vld_i,
  input  wire req_t        req_i,
  output logic             vld_o,
  output logic [31:0]      secs_o
);

  logic [3:0]  month_c;
  logic        leap;
  logic [15:0] y16;
  logic [15:0] yr_days;
  logic [15:0] leap_days;
  logic [16:0] days_d, days_q;
  logic [16:0] hms_d, hms_q, hms2_q;
  logic [31:0] prod_d, prod_q;
  logic [31:0] sum_d, sum_q;
  logic        v1_q, v2_q, v3_q;
  logic [31:0]        pad_q     [D2S_PAD];
  logic [D2S_PAD-1:0] pad_vld_q;

  // stage 1: day count and time of day
  always_comb begin
    if (req_i.in_month < 4'd1) begin
      month_c = 4'd1;
    end else if (req_i.in_month > 4'd12) begin
      month_c = 4'd12;
    end else begin
      month_c = req_i.in_month;
    end
    leap      = (req_i.in_year[1:0] == 2'b00);
    y16       = {9'd0, req_i.in_year};
    yr_days   = y16 * DAYS_PER_YEAR;
    leap_days = (y16 + 16'd3) >> 2;
    // day 0 gives minus one day; kept as two's complement
    days_d    = {1'b0, yr_days} + {1'b0, leap_days} + {8'd0, cum_days(month_c, leap)}
              + {12'd0, req_i.in_day} - 17'd1;
    hms_d     = ({12'd0, req_i.in_hour} * SECS_PER_HOUR)
              + ({11'd0, req_i.in_minute} * 17'd60)
              + {11'd0, req_i.in_second};
  end

  // stage 2: scale, stage 3: add (both modulo 2^32)
  assign prod_d = {{15{days_q[16]}}, days_q} * SECS_PER_DAY;
  assign sum_d  = prod_q + {15'd0, hms2_q};

  always_ff @(posedge clk_i) begin
    days_q <= days_d;
    hms_q  <= hms_d;
    prod_q <= prod_d;
    hms2_q <= hms_q;
    sum_q  <= sum_d;
    pad_q[0] <= sum_q;
    for (int i = 1; i < D2S_PAD; i++) begin
      pad_q[i] <= pad_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      pad_vld_q <= '0;
    end else begin
      v1_q      <= vld_i;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      pad_vld_q <= {pad_vld_q[D2S_PAD-2:0], v3_q};
    end
  end

  assign vld_o  = pad_vld_q[D2S_PAD-1];
  assign secs_o = pad_q[D2S_PAD-1];

endmodule

`default_nettype wire

@@ rtl/esdc_s2d.sv @@
// ----------------------------------------------------------------------------
// esdc_s2d
// Seconds to date-time: constant divisions by reciprocal multiply and one
// correction step, year within a four-year block, month by table compare.
// ----------------------------------------------------------------------------
`default_nettype none

module esdc_s2d import esdc_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  vld_i,
  input  wire req_t  req_i,
  output logic       vld_o,
  output res_t       res_o
);

  // stage 1
  logic [50:0] p1;
  logic [15:0] q1_q;
  logic [31:0] secs1_q;
  // stage 2
  logic [31:0] p2_d, p2_q;
  logic [15:0] q2_q;
  logic [31:0] secs2_q;
  // stage 3
  logic [31:0] r3;
  logic [15:0] days3_d, days3_q;
  logic [16:0] rem3_d, rem3_q;
  // stage 4
  logic [27:0] hp;
  logic [31:0] qp;
  logic [4:0]  hest4_q;
  logic [5:0]  qest4_q;
  logic [16:0] rem4_q;
  logic [15:0] days4_q;
  logic        rng4_q;
  // stage 5
  logic [16:0] r5;
  logic [15:0] d5;
  logic [4:0]  hour5_d, hour5_q;
  logic [11:0] rem5_d, rem5_q;
  logic [5:0]  quad5_d, quad5_q;
  logic [10:0] dq5_d, dq5_q;
  logic        rng5_q;
  // stage 6
  logic [22:0] mp;
  logic [1:0]  yoff;
  logic [8:0]  doy6_d, doy6_q;
  logic [7:0]  yr8;
  logic [5:0]  mest6_q;
  logic [11:0] rem6_q;
  logic [4:0]  hour6_q;
  logic [6:0]  year6_q;
  logic        leap6_q;
  logic        rng6_q;
  // stage 7
  logic [11:0] r7;
  logic [3:0]  mon;
  logic [8:0]  dom;
  res_t        res_d, res_q;
  logic        v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;

  assign p1   = {26'd0, req_i.in_epoch_seconds[31:7]} * {25'd0, DIV675_MUL};
  assign p2_d = {16'd0, q1_q} * SECS_PER_DAY;

  always_comb begin
    r3 = secs2_q - p2_q;
    if (r3 >= SECS_PER_DAY) begin
      days3_d = q2_q + 16'd1;
      rem3_d  = 17'(r3 - SECS_PER_DAY);
    end else begin
      days3_d = q2_q;
      rem3_d  = r3[16:0];
    end
  end

  assign hp = {11'd0, rem3_q} * {17'd0, HOUR_MUL};
  assign qp = {16'd0, days3_q} * {16'd0, QUAD_MUL};

  always_comb begin
    r5 = rem4_q - ({12'd0, hest4_q} * SECS_PER_HOUR);
    if (r5 >= SECS_PER_HOUR) begin
      hour5_d = hest4_q + 5'd1;
      rem5_d  = 12'(r5 - SECS_PER_HOUR);
    end else begin
      hour5_d = hest4_q;
      rem5_d  = r5[11:0];
    end
    d5 = days4_q - ({10'd0, qest4_q} * DAYS_PER_QUAD);
    if (d5 >= DAYS_PER_QUAD) begin
      quad5_d = qest4_q + 6'd1;
      dq5_d   = 11'(d5 - DAYS_PER_QUAD);
    end else begin
      quad5_d = qest4_q;
      dq5_d   = d5[10:0];
    end
  end

  assign mp = {11'd0, rem5_q} * {12'd0, MIN_MUL};

  always_comb begin
    if (dq5_q >= QUAD_Y3) begin
      yoff   = 2'd3;
      doy6_d = 9'(dq5_q - QUAD_Y3);
    end else if (dq5_q >= QUAD_Y2) begin
      yoff   = 2'd2;
      doy6_d = 9'(dq5_q - QUAD_Y2);
    end else if (dq5_q >= QUAD_Y1) begin
      yoff   = 2'd1;
      doy6_d = 9'(dq5_q - QUAD_Y1);
    end else begin
      yoff   = 2'd0;
      doy6_d = dq5_q[8:0];
    end
    yr8 = {quad5_q, 2'b00} + {6'd0, yoff};
  end

  always_comb begin
    r7  = rem6_q - ({6'd0, mest6_q} * SECS_PER_MIN);
    mon = 4'd1;
    for (int k = 2; k <= 12; k++) begin
      if (doy6_q >= cum_days(4'(k), leap6_q)) begin
        mon = 4'(k);
      end
    end
    dom   = doy6_q - cum_days(mon, leap6_q) + 9'd1;
    res_d = '0;
    if (rng6_q) begin
      res_d.range_error = 1'b1;
    end else begin
      res_d.out_year  = year6_q;
      res_d.out_month = mon;
      res_d.out_day   = dom[4:0];
      res_d.out_hour  = hour6_q;
      if (r7 >= SECS_PER_MIN) begin
        res_d.out_minute = mest6_q + 6'd1;
        res_d.out_second = 6'(r7 - SECS_PER_MIN);
      end else begin
        res_d.out_minute = mest6_q;
        res_d.out_second = r7[5:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    q1_q    <= p1[DIV675_SHIFT+15:DIV675_SHIFT];
    secs1_q <= req_i.in_epoch_seconds;
    p2_q    <= p2_d;
    q2_q    <= q1_q;
    secs2_q <= secs1_q;
    days3_q <= days3_d;
    rem3_q  <= rem3_d;
    hest4_q <= hp[26:22];
    qest4_q <= qp[31:26];
    rem4_q  <= rem3_q;
    days4_q <= days3_q;
    rng4_q  <= (days3_q >= DAYS_UNTIL_2100);
    hour5_q <= hour5_d;
    rem5_q  <= rem5_d;
    quad5_q <= quad5_d;
    dq5_q   <= dq5_d;
    rng5_q  <= rng4_q;
    mest6_q <= mp[21:16];
    rem6_q  <= rem5_q;
    hour6_q <= hour5_q;
    year6_q <= yr8[6:0];
    leap6_q <= (yoff == 2'd0);
    doy6_q  <= doy6_d;
    rng6_q  <= rng5_q;
    res_q   <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  assign vld_o = v7_q;
  assign res_o = res_q;

`ifndef SYNTHESIS
  a_time_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v7_q && !res_q.range_error |->
      res_q.out_hour < 5'd24 && res_q.out_minute < 6'd60 && res_q.out_second < 6'd60)
    else $error("time of day out of range");

  a_date_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v7_q && !res_q.range_error |->
      res_q.out_month >= 4'd1 && res_q.out_month <= 4'd12 &&
      res_q.out_day >= 5'd1 && res_q.out_year <= 7'd99)
    else $error("date out of range");
`endif

endmodule

`default_nettype wire

@@ rtl/epoch_seconds_date_converter_top.sv @@
// ----------------------------------------------------------------------------
// epoch_seconds_date_converter_top
// Converts between a calendar date-time from 2000 and seconds since
// 2000-01-01 00:00:00, in either direction.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on req_i at each rising edge where start_i is high and
//   busy_o is low. busy_o is always low: a request may be issued every cycle.
//   req_i.func selects the direction (0 date to seconds, 1 seconds to date).
//   Each request gives one result on res_o, flagged by done_o for a single
//   cycle. Results leave in request order, one per cycle at most.
//   The latency is set by the seconds-to-date pipe: seven stages of constant
//   divisions (reciprocal multiply then correction) and month lookup, plus
//   the output register. The date-to-seconds pipe is three stages, padded.
//   The receiver cannot hold results off and nothing is buffered.
//   Reset clears all in-flight requests; no result is produced for them.
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_seconds_date_converter_top import esdc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  output logic      busy_o,
  input  wire req_t req_i,
  output logic      done_o,
  output res_t      res_o
);

  logic        d2s_vld_in, s2d_vld_in;
  logic        d2s_vld, s2d_vld;
  logic [31:0] d2s_secs;
  res_t        s2d_res;
  res_t        res_d, res_q;
  logic        done_d, done_q;

  assign busy_o     = 1'b0;
  assign d2s_vld_in = start_i && !busy_o && (req_i.func == FUNC_DATE_TO_SECS);
  assign s2d_vld_in = start_i && !busy_o && (req_i.func == FUNC_SECS_TO_DATE);

  esdc_d2s u_d2s (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (d2s_vld_in),
    .req_i  (req_i),
    .vld_o  (d2s_vld),
    .secs_o (d2s_secs)
  );

  esdc_s2d u_s2d (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (s2d_vld_in),
    .req_i  (req_i),
    .vld_o  (s2d_vld),
    .res_o  (s2d_res)
  );

  always_comb begin
    done_d = d2s_vld || s2d_vld;
    if (d2s_vld) begin
      res_d                   = '0;
      res_d.out_epoch_seconds = d2s_secs;
    end else begin
      res_d = s2d_res;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef SYNTHESIS
  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({d2s_vld, s2d_vld}))
    else $error("both conversion pipes finished in one cycle");

  a_done_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, TOP_LATENCY))
    else $error("result without a matching request");

  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.range_error |->
      res_o.out_epoch_seconds == 32'd0 && res_o.out_year == 7'd0 &&
      res_o.out_month == 4'd0 && res_o.out_day == 5'd0)
    else $error("range error with non-zero fields");
`endif

endmodule

`default_nettype wire

@@ tb/epoch_seconds_date_converter_top_test.sv @@
// ----------------------------------------------------------------------------
// epoch_seconds_date_converter_top_test
// Self-checking bench for the epoch seconds / calendar date converter. A queue
// of requests (directed corner cases, then random dates and second counts)
// feeds a clocked driver with random idle gaps. A monitor predicts each
// accepted request and compares every field of each result in order.
// ----------------------------------------------------------------------------
module epoch_seconds_date_converter_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import esdc_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RANDOM_REQS = 1625;
  localparam logic [31:0] END_OF_2099 = 32'd3155760000;
  localparam int unsigned MONTH_LEN[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct {
    req_t        req;
    int unsigned gap;
    bit          drain;
  } queued_req_t;

  logic clk_i   = 1'b0;
  logic rst_ni  = 1'b0;
  logic start_i = 1'b0;
  req_t req_i   = '0;
  logic busy_o;
  logic done_o;
  res_t res_o;

  queued_req_t requests_queued[$];
  res_t        conversions_due[$];
  queued_req_t staged_req;
  bit          staged = 1'b0;
  int unsigned gap_cnt = 0;
  int unsigned calm_left = 0;
  int unsigned stall_cnt = 0;
  int unsigned err_cnt = 0;
  logic        req_taken = 1'b0;

  epoch_seconds_date_converter_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int unsigned month_days(logic [31:0] m0, bit leap);
    if (m0 == 1 && leap) begin
      return 29;
    end
    return MONTH_LEN[m0 % 12];
  endfunction

  function automatic res_t convert_date_time(req_t r);
    res_t        o;
    logic [31:0] days;
    logic [31:0] rem;
    logic [31:0] yr;
    logic [31:0] mo;
    bit          leap;
    o = '0;
    if (r.func == FUNC_DATE_TO_SECS) begin
      yr   = 32'(r.in_year);
      mo   = 32'(r.in_month);
      leap = (yr[1:0] == 2'd0);
      if (mo < 1) mo = 1;
      if (mo > 12) mo = 12;
      days = yr * 365 + ((yr + 3) >> 2);
      for (int i = 0; i + 1 < mo; i++) begin
        days = days + month_days(i, leap);
      end
      days = days + 32'(r.in_day) - 1;
      o.out_epoch_seconds = ((days * 24 + 32'(r.in_hour)) * 60 + 32'(r.in_minute)) * 60
                          + 32'(r.in_second);
    end else begin
      days = r.in_epoch_seconds / 86400;
      rem  = r.in_epoch_seconds % 86400;
      if (days >= 36525) begin
        o.range_error = 1'b1;
      end else begin
        o.out_hour   = 5'(rem / 3600);
        rem          = rem % 3600;
        o.out_minute = 6'(rem / 60);
        o.out_second = 6'(rem % 60);
        yr   = 4 * (days / 1461);
        days = days % 1461;
        if (days >= 366) begin
          days = days - 366;
          yr++;
          if (days >= 365) begin
            days = days - 365;
            yr++;
            if (days >= 365) begin
              days = days - 365;
              yr++;
            end
          end
        end
        leap = (yr[1:0] == 2'd0);
        mo   = 1;
        for (int i = 0; i < 11; i++) begin
          if (days < month_days(i, leap)) break;
          days = days - month_days(i, leap);
          mo++;
        end
        o.out_year  = yr[6:0];
        o.out_month = mo[3:0];
        o.out_day   = days[4:0] + 5'd1;
      end
    end
    return o;
  endfunction

  function automatic req_t noise_req();
    logic [95:0] bits;
    bits = {$urandom, $urandom, $urandom};
    return bits[$bits(req_t)-1:0];
  endfunction

  function automatic req_t date_req(int unsigned y, int unsigned mo, int unsigned d,
                                    int unsigned h, int unsigned mi, int unsigned s);
    req_t r;
    r           = noise_req();
    r.func      = FUNC_DATE_TO_SECS;
    r.in_year   = 7'(y);
    r.in_month  = 4'(mo);
    r.in_day    = 5'(d);
    r.in_hour   = 5'(h);
    r.in_minute = 6'(mi);
    r.in_second = 6'(s);
    return r;
  endfunction

  function automatic req_t secs_req(logic [31:0] s);
    req_t r;
    r                  = noise_req();
    r.func             = FUNC_SECS_TO_DATE;
    r.in_epoch_seconds = s;
    return r;
  endfunction

  // idle gap ahead of each request; occasional stretches run back to back
  task automatic queue_req(req_t r, bit drain);
    queued_req_t q;
    int unsigned p;
    q.req   = r;
    q.drain = drain;
    p       = $urandom_range(99);
    if (calm_left != 0) begin
      q.gap = 0;
      calm_left--;
    end else if (p < 45) begin
      q.gap = 0;
    end else if (p < 85) begin
      q.gap = $urandom_range(3, 1);
    end else if (p < 97) begin
      q.gap = $urandom_range(12, 4);
    end else begin
      q.gap = $urandom_range(60, 20);
    end
    if ($urandom_range(149) == 0) begin
      calm_left = $urandom_range(120, 60);
    end
    requests_queued.push_back(q);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  // driver
  always @(negedge clk_i) begin
    bit go;
    go = 1'b0;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (!(start_i && !req_taken)) begin
      if (!staged && requests_queued.size() != 0) begin
        staged_req = requests_queued.pop_front();
        staged     = 1'b1;
        gap_cnt    = staged_req.gap;
      end
      if (staged && gap_cnt != 0) begin
        gap_cnt--;
      end else if (staged && !(staged_req.drain && conversions_due.size() != 0)) begin
        go = 1'b1;
      end
      if (go) begin
        start_i <= 1'b1;
        req_i   <= staged_req.req;
        staged   = 1'b0;
      end else begin
        start_i <= 1'b0;
        req_i   <= noise_req();
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    res_t want;
    req_taken <= rst_ni && start_i && !busy_o;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        conversions_due.push_back(convert_date_time(req_i));
      end
      if (done_o) begin
        if (conversions_due.size() == 0) begin
          $error("result with no request outstanding");
          err_cnt++;
        end else begin
          want = conversions_due.pop_front();
          check_field("out_epoch_seconds", want.out_epoch_seconds, res_o.out_epoch_seconds);
          check_field("out_year", 32'(want.out_year), 32'(res_o.out_year));
          check_field("out_month", 32'(want.out_month), 32'(res_o.out_month));
          check_field("out_day", 32'(want.out_day), 32'(res_o.out_day));
          check_field("out_hour", 32'(want.out_hour), 32'(res_o.out_hour));
          check_field("out_minute", 32'(want.out_minute), 32'(res_o.out_minute));
          check_field("out_second", 32'(want.out_second), 32'(res_o.out_second));
          check_field("range_error", 32'(want.range_error), 32'(res_o.range_error));
        end
      end
      if ((start_i && !busy_o) || done_o) begin
        stall_cnt = 0;
      end else begin
        stall_cnt++;
      end
      if (stall_cnt >= STALL_LIMIT) begin
        $display("[epoch_seconds_date_converter_top] ERROR");
        $finish;
      end
    end
  end

  initial begin
    int unsigned p;
    int unsigned y;
    int unsigned mo;
    int unsigned d;
    logic [31:0] base;
    req_t        r;
    res_t        conv;

    queue_req(date_req(0, 1, 1, 0, 0, 0), 1'b0);
    queue_req(date_req(99, 12, 31, 23, 59, 59), 1'b0);
    queue_req(date_req(0, 2, 29, 12, 30, 30), 1'b0);
    queue_req(date_req(1, 3, 1, 0, 0, 0), 1'b0);
    queue_req(date_req(4, 3, 1, 6, 7, 8), 1'b0);
    queue_req(date_req(10, 0, 15, 1, 2, 3), 1'b0);
    queue_req(date_req(10, 13, 15, 1, 2, 3), 1'b0);
    queue_req(date_req(10, 15, 31, 1, 2, 3), 1'b0);
    queue_req(date_req(0, 1, 0, 0, 0, 0), 1'b0);
    queue_req(date_req(127, 15, 31, 31, 63, 63), 1'b0);
    queue_req(secs_req(32'd0), 1'b1);
    queue_req(secs_req(32'd59), 1'b0);
    queue_req(secs_req(32'd86399), 1'b0);
    queue_req(secs_req(32'd86400), 1'b0);
    queue_req(secs_req(32'd5183999), 1'b0);
    queue_req(secs_req(32'd31622399), 1'b0);
    queue_req(secs_req(32'd31622400), 1'b0);
    queue_req(secs_req(32'd126230399), 1'b0);
    queue_req(secs_req(32'd126230400), 1'b0);
    queue_req(secs_req(END_OF_2099 - 1), 1'b0);
    queue_req(secs_req(END_OF_2099), 1'b0);
    queue_req(secs_req(32'hFFFF_FFFF), 1'b0);

    for (int n = 0; n < RANDOM_REQS; n++) begin
      p = $urandom_range(99);
      if (p < 40) begin
        y  = $urandom_range(99);
        mo = $urandom_range(12, 1);
        d  = $urandom_range(month_days(mo - 1, y % 4 == 0), 1);
        r  = date_req(y, mo, d, $urandom_range(23), $urandom_range(59), $urandom_range(59));
      end else if (p < 50) begin
        r      = noise_req();
        r.func = FUNC_DATE_TO_SECS;
      end else if (p < 80) begin
        r = secs_req($urandom_range(32'd3155759999, 0));
      end else if (p < 88) begin
        // around the start or end of a month
        y    = $urandom_range(99);
        mo   = $urandom_range(12, 1);
        d    = ($urandom_range(1) == 0) ? 1 : month_days(mo - 1, y % 4 == 0);
        conv = convert_date_time(date_req(y, mo, d, 0, 0, 0));
        base = conv.out_epoch_seconds;
        r    = secs_req(base + $urandom_range(86401) - 1);
      end else if (p < 95) begin
        r = secs_req($urandom);
      end else begin
        r = secs_req(END_OF_2099 + $urandom_range(200) - 100);
      end
      queue_req(r, (n % 400) == 399);
    end

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (requests_queued.size() != 0 || staged || start_i) @(posedge clk_i);
    while (conversions_due.size() != 0) @(posedge clk_i);
    repeat (TOP_LATENCY + 4) @(posedge clk_i);

    if (err_cnt == 0 && conversions_due.size() == 0) begin
      $display("[epoch_seconds_date_converter_top] OK");
    end else begin
      $display("[epoch_seconds_date_converter_top] ERROR");
    end
    $finish;
  end

endmodule
